// ===== rtl/rsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rsd_pkg: range sample decoder shared definitions
// Widths, status codes, raw special codes and scaling constants.
// ----------------------------------------------------------------------------
package rsd_pkg;

	localparam int BYTE_W   = 8;
	localparam int RAW_W    = 14;
	localparam int REG_W    = 20;
	localparam int ST_W     = 4;
	localparam int DIST_W   = 23;
	localparam int EVT_W    = 32;
	localparam int CIDX_W   = 3;

	// saturating event counters, one per special status
	localparam int CNT_BITS = 32;
	localparam int CNT_N    = 7;
	localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

	// distance = start + round(range * (102*raw - 16368) / 1636800)
	localparam int MAG_W    = 21;
	localparam int PROD_W   = REG_W + MAG_W;
	// rounded magnitude stays below 2^PROD_W
	localparam int DVD_W    = PROD_W;
	localparam int QUO_W    = 21;
	localparam int DEN_W    = 21;
	localparam int REM_W    = DEN_W + 2;
	localparam int RECIP_W  = 32;
	localparam int MULP_W   = QUO_W + RECIP_W;
	// estimate, back multiply, two corrections
	localparam int DIV_STEPS = 4;
	localparam int DCNT_W   = $clog2(DIV_STEPS + 1);

	localparam logic [MAG_W-1:0] SCALE_MUL  = MAG_W'(102);
	localparam logic [MAG_W-1:0] SCALE_OFF  = MAG_W'(16368);
	localparam logic [DEN_W-1:0] SCALE_DEN  = DEN_W'(1636800);
	localparam logic [DVD_W-1:0] SCALE_HALF = DVD_W'(818400);
	// floor(2^(DVD_W - QUO_W + RECIP_W) / SCALE_DEN)
	localparam logic [RECIP_W-1:0] SCALE_RECIP =
		RECIP_W'((64'd1 << (DVD_W - QUO_W + RECIP_W)) / 64'(SCALE_DEN));

	localparam logic [REG_W-1:0] RANGE_RST = REG_W'(600000);
	localparam logic [REG_W-1:0] START_RST = REG_W'(200000);

	// configuration register indexes
	localparam logic CFG_RANGE = 1'b0;
	localparam logic CFG_START = 1'b1;

	// raw codes
	localparam logic [RAW_W-1:0] RAW_MEAS_MAX = RAW_W'(16367);
	localparam logic [RAW_W-1:0] RAW_NO_OBJ   = RAW_W'(16370);
	localparam logic [RAW_W-1:0] RAW_CLOSE    = RAW_W'(16372);
	localparam logic [RAW_W-1:0] RAW_FAR      = RAW_W'(16374);
	localparam logic [RAW_W-1:0] RAW_UNEVAL   = RAW_W'(16376);
	localparam logic [RAW_W-1:0] RAW_TOWARD   = RAW_W'(16380);
	localparam logic [RAW_W-1:0] RAW_AWAY     = RAW_W'(16382);

	// status codes
	localparam logic [ST_W-1:0] ST_VALID   = ST_W'(0);
	localparam logic [ST_W-1:0] ST_NO_OBJ  = ST_W'(1);
	localparam logic [ST_W-1:0] ST_CLOSE   = ST_W'(2);
	localparam logic [ST_W-1:0] ST_FAR     = ST_W'(3);
	localparam logic [ST_W-1:0] ST_UNEVAL  = ST_W'(4);
	localparam logic [ST_W-1:0] ST_TOWARD  = ST_W'(5);
	localparam logic [ST_W-1:0] ST_AWAY    = ST_W'(6);
	localparam logic [ST_W-1:0] ST_UNKNOWN = ST_W'(7);
	localparam logic [ST_W-1:0] ST_FRAME   = ST_W'(8);

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/rsd_if.sv =====
// ----------------------------------------------------------------------------
// rsd_if: range sample decoder channel interfaces
// Valid/ready channels for byte pair requests and decoded results.
// ----------------------------------------------------------------------------
interface rsd_in_if;
	logic                       valid;
	logic                       ready;
	logic [rsd_pkg::BYTE_W-1:0] high_byte;
	logic [rsd_pkg::BYTE_W-1:0] low_byte;

	modport source (output valid, output high_byte, output low_byte, input ready);
	modport sink   (input valid, input high_byte, input low_byte, output ready);
endinterface

interface rsd_out_if;
	logic                              valid;
	logic                              ready;
	logic [rsd_pkg::ST_W-1:0]          status;
	logic signed [rsd_pkg::DIST_W-1:0] distance_um;
	logic [rsd_pkg::EVT_W-1:0]         event_count;

	modport source (output valid, output status, output distance_um, output event_count,
		input ready);
	modport sink   (input valid, input status, input distance_um, input event_count,
		output ready);
endinterface

// ===== rtl/rsd_div.sv =====
// ----------------------------------------------------------------------------
// rsd_div: iterative scaling divider
// Division by the fixed scale denominator: reciprocal estimate and back
// multiply on one shared multiplier, then two correction steps.
// ----------------------------------------------------------------------------
module rsd_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rsd_pkg::div_req_t req,
	output rsd_pkg::div_rsp_t rsp
);

	logic [rsd_pkg::DVD_W-1:0]   num_q;
	logic [rsd_pkg::QUO_W-1:0]   quo_q;
	logic [rsd_pkg::REM_W-1:0]   rem_q;
	logic [rsd_pkg::DCNT_W-1:0]  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic                        est_step;
	logic                        back_step;
	logic [rsd_pkg::QUO_W-1:0]   mul_a;
	logic [rsd_pkg::RECIP_W-1:0] mul_b;
	logic [rsd_pkg::MULP_W-1:0]  prod;
	logic [rsd_pkg::DVD_W-1:0]   back_rem;

	assign est_step  = busy_q && (cnt_q == rsd_pkg::DCNT_W'(rsd_pkg::DIV_STEPS));
	assign back_step = busy_q && (cnt_q == rsd_pkg::DCNT_W'(rsd_pkg::DIV_STEPS - 1));

	// estimate from the top dividend bits falls short by at most two
	assign mul_a    = est_step ? num_q[rsd_pkg::DVD_W-1 -: rsd_pkg::QUO_W] : quo_q;
	assign mul_b    = est_step ? rsd_pkg::SCALE_RECIP : rsd_pkg::RECIP_W'(rsd_pkg::SCALE_DEN);
	assign prod     = rsd_pkg::MULP_W'(mul_a) * rsd_pkg::MULP_W'(mul_b);
	assign back_rem = num_q - prod[rsd_pkg::DVD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= rsd_pkg::DCNT_W'(rsd_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rsd_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
		end else if (est_step) begin
			quo_q <= prod[rsd_pkg::MULP_W-1 -: rsd_pkg::QUO_W];
		end else if (back_step) begin
			rem_q <= rsd_pkg::REM_W'(back_rem);
		end else if (busy_q && rem_q >= rsd_pkg::REM_W'(rsd_pkg::SCALE_DEN)) begin
			rem_q <= rem_q - rsd_pkg::REM_W'(rsd_pkg::SCALE_DEN);
			quo_q <= quo_q + 1'b1;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== rtl/rsd_cnt_bank.sv =====
// ----------------------------------------------------------------------------
// rsd_cnt_bank: special status event counters
// Seven saturating counters; bumps the selected one and returns its new value.
// ----------------------------------------------------------------------------
module rsd_cnt_bank (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         inc,
	input  logic [rsd_pkg::CIDX_W-1:0]   idx,
	output logic [rsd_pkg::CNT_BITS-1:0] next_cnt
);

	logic [rsd_pkg::CNT_N-1:0][rsd_pkg::CNT_BITS-1:0] cnt_q;
	logic [rsd_pkg::CNT_BITS-1:0]                     cur;

	assign cur      = cnt_q[idx];
	assign next_cnt = (cur == rsd_pkg::CNT_MAX) ? cur : cur + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (inc) begin
			cnt_q[idx] <= next_cnt;
		end
	end

endmodule

// ===== rtl/range_sample_decoder.sv =====
// ----------------------------------------------------------------------------
// range_sample_decoder: laser range sensor sample decoder
// Checks framing of a byte pair, classifies the raw value, scales
// measurements to micrometres and counts special conditions.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                 | handshake
//  sample  | in  | high_byte[7:0], low_byte[7:0]           | valid/ready
//  result  | out | status[3:0], distance_um[22:0] signed,  | valid/ready
//          |     | event_count[31:0]                       |
//  cfg     | in  | cfg_index (0 range, 1 start), cfg_data  | cfg_we, no wait
//
//  A measurement passes from acceptance to the result register through
//  classify, multiply, rounding add, 4 divider steps, final add, handoff.
//  Framing errors and special codes go to handoff (codes counted in classify).
//  The divider's reciprocal estimate, back multiply and two corrections set
//  the measurement latency.
//  Reset clears the counters and loads range 600000 um, start 200000 um.
//  A new request is taken while the previous result waits in the output
//  register; a stalled result holds the sequencer in its handoff step.
// ----------------------------------------------------------------------------
module range_sample_decoder (
	input  logic                      clk,
	input  logic                      arst_n,
	rsd_in_if.sink                    sample,
	rsd_out_if.source                 result,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [rsd_pkg::REG_W-1:0] cfg_data
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_CLS  = 6'b000010,
		S_MUL  = 6'b000100,
		S_RND  = 6'b001000,
		S_DIV  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q;

	logic [rsd_pkg::REG_W-1:0]  range_q;
	logic [rsd_pkg::REG_W-1:0]  start_q;
	logic [rsd_pkg::BYTE_W-1:0] hi_q;
	logic [rsd_pkg::BYTE_W-1:0] lo_q;
	logic [rsd_pkg::MAG_W-1:0]  mag_q;
	logic                       neg_q;
	logic [rsd_pkg::PROD_W-1:0] prod_q;

	logic [rsd_pkg::ST_W-1:0]          res_st_q;
	logic signed [rsd_pkg::DIST_W-1:0] res_dist_q;
	logic [rsd_pkg::EVT_W-1:0]         res_evt_q;

	logic                              ovalid_q;
	logic [rsd_pkg::ST_W-1:0]          ost_q;
	logic signed [rsd_pkg::DIST_W-1:0] odist_q;
	logic [rsd_pkg::EVT_W-1:0]         oevt_q;

	logic [rsd_pkg::RAW_W-1:0]    raw;
	logic                         frame_err;
	logic [rsd_pkg::ST_W-1:0]     st;
	logic [rsd_pkg::MAG_W-1:0]    raw_x;
	logic [rsd_pkg::CIDX_W-1:0]   cidx;
	logic                         cnt_inc;
	logic [rsd_pkg::CNT_BITS-1:0] cnt_next;
	logic [63:0]                  cnt_wide;
	logic [rsd_pkg::DIST_W-1:0]   quo_ext;
	logic [rsd_pkg::DIST_W-1:0]   dist_sum;
	logic                         handoff;
	rsd_pkg::div_req_t            div_req;
	rsd_pkg::div_rsp_t            div_rsp;

	assign sample.ready = (state_q == S_IDLE);
	assign handoff      = (state_q == S_DONE) && (!ovalid_q || result.ready);

	// classification
	assign frame_err = !hi_q[rsd_pkg::BYTE_W-1] || lo_q[rsd_pkg::BYTE_W-1];
	assign raw       = {hi_q[rsd_pkg::BYTE_W-2:0], lo_q[rsd_pkg::BYTE_W-2:0]};
	assign raw_x     = rsd_pkg::MAG_W'(raw) * rsd_pkg::SCALE_MUL;

	always_comb begin
		if (raw <= rsd_pkg::RAW_MEAS_MAX) begin
			st = rsd_pkg::ST_VALID;
		end else begin
			unique case (raw)
				rsd_pkg::RAW_NO_OBJ: st = rsd_pkg::ST_NO_OBJ;
				rsd_pkg::RAW_CLOSE:  st = rsd_pkg::ST_CLOSE;
				rsd_pkg::RAW_FAR:    st = rsd_pkg::ST_FAR;
				rsd_pkg::RAW_UNEVAL: st = rsd_pkg::ST_UNEVAL;
				rsd_pkg::RAW_TOWARD: st = rsd_pkg::ST_TOWARD;
				rsd_pkg::RAW_AWAY:   st = rsd_pkg::ST_AWAY;
				default:             st = rsd_pkg::ST_UNKNOWN;
			endcase
		end
	end

	assign cidx    = rsd_pkg::CIDX_W'(st - 1'b1);
	assign cnt_inc = (state_q == S_CLS) && !frame_err && (st != rsd_pkg::ST_VALID);

	rsd_cnt_bank u_cnt (
		.clk      (clk),
		.arst_n   (arst_n),
		.inc      (cnt_inc),
		.idx      (cidx),
		.next_cnt (cnt_next)
	);

	assign cnt_wide = 64'(cnt_next);

	assign div_req.start    = (state_q == S_RND);
	assign div_req.dividend = prod_q + rsd_pkg::SCALE_HALF;

	rsd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign quo_ext  = rsd_pkg::DIST_W'(div_rsp.quotient);
	assign dist_sum = rsd_pkg::DIST_W'(start_q) + (neg_q ? (~quo_ext + 1'b1) : quo_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= rsd_pkg::RANGE_RST;
			start_q <= rsd_pkg::START_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rsd_pkg::CFG_RANGE: range_q <= cfg_data;
				rsd_pkg::CFG_START: start_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (handoff) begin
				ovalid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (sample.valid) state_q <= S_CLS;
				S_CLS: begin
					if (frame_err || st != rsd_pkg::ST_VALID) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_RND;
				S_RND: state_q <= S_DIV;
				S_DIV: if (div_rsp.done) state_q <= S_DONE;
				S_DONE: begin
					if (handoff) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			hi_q <= sample.high_byte;
			lo_q <= sample.low_byte;
		end
		if (state_q == S_CLS) begin
			if (raw_x >= rsd_pkg::SCALE_OFF) begin
				mag_q <= raw_x - rsd_pkg::SCALE_OFF;
				neg_q <= 1'b0;
			end else begin
				mag_q <= rsd_pkg::SCALE_OFF - raw_x;
				neg_q <= 1'b1;
			end
			res_dist_q <= '0;
			if (frame_err) begin
				res_st_q  <= rsd_pkg::ST_FRAME;
				res_evt_q <= '0;
			end else begin
				res_st_q  <= st;
				res_evt_q <= (st == rsd_pkg::ST_VALID) ? '0 : cnt_wide[rsd_pkg::EVT_W-1:0];
			end
		end
		if (state_q == S_MUL) begin
			prod_q <= rsd_pkg::PROD_W'(range_q) * rsd_pkg::PROD_W'(mag_q);
		end
		if (state_q == S_DIV && div_rsp.done) begin
			res_dist_q <= dist_sum;
		end
		if (handoff) begin
			ost_q   <= res_st_q;
			odist_q <= res_dist_q;
			oevt_q  <= res_evt_q;
		end
	end

	assign result.valid       = ovalid_q;
	assign result.status      = ost_q;
	assign result.distance_um = odist_q;
	assign result.event_count = oevt_q;

	a_dist_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status != rsd_pkg::ST_VALID |-> result.distance_um == '0)
		else $error("distance nonzero on a non-measurement result");

	a_evt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.status == rsd_pkg::ST_VALID ||
		result.status == rsd_pkg::ST_FRAME) |-> result.event_count == '0)
		else $error("event count nonzero on measurement or framing error");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider finished outside the divide step");

	a_accept_cls: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> state_q == S_CLS)
		else $error("accepted request did not enter classification");

	a_no_busy_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !div_rsp.busy)
		else $error("divider busy while sequencer idle");

endmodule
